### hw/rtl/rvb_pkg.sv
// ----------------------------------------------------------------------------
// Reciprocal voxel binning package
// Shared constants, codes and types of the voxel binning block.
// ----------------------------------------------------------------------------
package rvb_pkg;

  localparam int GRID_DEFAULT = 32;
  localparam int HALF_DIV = 2;
  localparam int ADDR_W = 15;
  localparam int STORE_DEPTH = 1 << ADDR_W;
  localparam int SUM_W = 64;
  localparam int HITS_W = 32;
  localparam int ADD_W = 55;
  localparam int Q_DEPTH = 4;
  localparam logic [23:0] CLIP_LIMIT = 24'hFFFFFF;

  localparam logic OP_ACCUM = 1'b0;
  localparam logic OP_READ = 1'b1;

  localparam logic [1:0] REG_ROW_X = 2'd0;
  localparam logic [1:0] REG_ROW_Y = 2'd1;
  localparam logic [1:0] REG_ROW_Z = 2'd2;
  localparam logic [1:0] REG_LORENTZ = 2'd3;

  typedef struct packed {
    logic [47:0] row_x;
    logic [47:0] row_y;
    logic [47:0] row_z;
    logic        lorentz_en;
  } cfg_t;

  typedef struct packed {
    logic              op;
    logic              hit;
    logic [ADDR_W-1:0] addr;
    logic [ADD_W-1:0]  add;
  } work_t;

endpackage

### hw/rtl/reciprocal_voxel_binning.sv
// ----------------------------------------------------------------------------
// Reciprocal voxel binning
// Bins pixels into a 3D voxel grid and reads back per-voxel averages.
// An accumulate word passes the front's input registers, the queue and the
// back's execute state, where its voxel is read, modified and written; the
// back takes a new queued word only once the last one is through. A readout
// of a filled voxel holds the back while the 64-step divider runs.
// After reset a clearing pass over all 32768 voxels zeroes the stores; input
// ready stays low meanwhile, configuration writes are taken as ever.
// ----------------------------------------------------------------------------
module reciprocal_voxel_binning #(
  parameter int GRID_X = rvb_pkg::GRID_DEFAULT,
  parameter int GRID_Y = rvb_pkg::GRID_DEFAULT,
  parameter int GRID_Z = rvb_pkg::GRID_DEFAULT
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [4:0]                 paddr,
  input  logic [63:0]                pwdata,
  output logic [63:0]                prdata,
  output logic                       pready,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       operation,
  input  logic signed [23:0]         recip_x,
  input  logic signed [23:0]         recip_y,
  input  logic signed [23:0]         recip_z,
  input  logic signed [31:0]         pixel_intensity,
  input  logic [23:0]                lorentz_factor,
  input  logic [rvb_pkg::ADDR_W-1:0] voxel_address,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       landed,
  output logic [rvb_pkg::ADDR_W-1:0] landed_address,
  output logic [31:0]                average_value,
  output logic                       voxel_filled
);
  import rvb_pkg::*;

  cfg_t       cfg;
  logic       take;
  logic       s1_valid;
  logic       push;
  work_t      push_data;
  logic       pop;
  logic       head_valid;
  work_t      head_data;
  logic [2:0] count;
  logic       clearing;

  assign pready = 1'b1;
  assign take = in_valid && in_ready;
  assign in_ready = !clearing && ((count + 3'(s1_valid)) < 3'(Q_DEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (psel && penable && pwrite) begin
      case (paddr[4:3])
        REG_ROW_X: cfg.row_x <= pwdata[47:0];
        REG_ROW_Y: cfg.row_y <= pwdata[47:0];
        REG_ROW_Z: cfg.row_z <= pwdata[47:0];
        REG_LORENTZ: cfg.lorentz_en <= pwdata[0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[4:3])
      REG_ROW_X: prdata = {16'b0, cfg.row_x};
      REG_ROW_Y: prdata = {16'b0, cfg.row_y};
      REG_ROW_Z: prdata = {16'b0, cfg.row_z};
      REG_LORENTZ: prdata = {63'b0, cfg.lorentz_en};
      default: prdata = '0;
    endcase
  end

  rvb_front #(
    .GRID_X (GRID_X),
    .GRID_Y (GRID_Y),
    .GRID_Z (GRID_Z)
  ) u_front (
    .clk             (clk),
    .rst             (rst),
    .cfg             (cfg),
    .take            (take),
    .operation       (operation),
    .recip_x         (recip_x),
    .recip_y         (recip_y),
    .recip_z         (recip_z),
    .pixel_intensity (pixel_intensity),
    .lorentz_factor  (lorentz_factor),
    .voxel_address   (voxel_address),
    .s1_valid        (s1_valid),
    .push            (push),
    .push_data       (push_data)
  );

  rvb_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (push_data),
    .pop        (pop),
    .head_valid (head_valid),
    .head_data  (head_data),
    .count      (count)
  );

  rvb_back u_back (
    .clk            (clk),
    .rst            (rst),
    .head_valid     (head_valid),
    .head_data      (head_data),
    .pop            (pop),
    .clearing       (clearing),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .landed         (landed),
    .landed_address (landed_address),
    .average_value  (average_value),
    .voxel_filled   (voxel_filled)
  );

endmodule

### hw/rtl/rvb_queue.sv
// ----------------------------------------------------------------------------
// Work queue
// Short FIFO of classified words between the front and the back.
// ----------------------------------------------------------------------------
module rvb_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  rvb_pkg::work_t push_data,
  input  logic           pop,
  output logic           head_valid,
  output rvb_pkg::work_t head_data,
  output logic [2:0]     count
);
  import rvb_pkg::*;

  work_t     entries [Q_DEPTH];
  logic [1:0] wr_ptr;
  logic [1:0] rd_ptr;

  assign head_valid = (count != 3'd0);
  assign head_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 2'd1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 2'd1;
      end
      count <= count + 3'(push) - 3'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

### hw/rtl/rvb_front.sv
// ----------------------------------------------------------------------------
// Voxel binning front
// Registers the matrix products and the weighted intensity, then finds the
// voxel of each pixel and hands a classified word to the queue.
// ----------------------------------------------------------------------------
module rvb_front #(
  parameter int GRID_X = rvb_pkg::GRID_DEFAULT,
  parameter int GRID_Y = rvb_pkg::GRID_DEFAULT,
  parameter int GRID_Z = rvb_pkg::GRID_DEFAULT
) (
  input  logic                      clk,
  input  logic                      rst,
  input  rvb_pkg::cfg_t             cfg,
  input  logic                      take,
  input  logic                      operation,
  input  logic signed [23:0]        recip_x,
  input  logic signed [23:0]        recip_y,
  input  logic signed [23:0]        recip_z,
  input  logic signed [31:0]        pixel_intensity,
  input  logic [23:0]               lorentz_factor,
  input  logic [rvb_pkg::ADDR_W-1:0] voxel_address,
  output logic                      s1_valid,
  output logic                      push,
  output rvb_pkg::work_t            push_data
);
  import rvb_pkg::*;

  localparam int YZ = GRID_Y * GRID_Z;

  logic signed [39:0] prod [3][3];
  logic               s1_op;
  logic               s1_neg;
  logic [ADDR_W-1:0]  s1_addr;
  logic [ADD_W-1:0]   s1_add;
  logic signed [41:0] acc [3];
  logic signed [15:0] cx;
  logic signed [15:0] cy;
  logic signed [15:0] cz;
  logic               in_grid;
  logic [31:0]        flat;
  logic [47:0]        rows [3];
  logic signed [23:0] vec [3];

  assign rows[0] = cfg.row_x;
  assign rows[1] = cfg.row_y;
  assign rows[2] = cfg.row_z;
  assign vec[0] = recip_x;
  assign vec[1] = recip_y;
  assign vec[2] = recip_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= take;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          prod[r][c] <= $signed(rows[r][16*c +: 16]) * vec[c];
        end
      end
      s1_op <= operation;
      s1_neg <= pixel_intensity[31];
      s1_addr <= voxel_address;
      if (cfg.lorentz_en) begin
        s1_add <= pixel_intensity[30:0] * lorentz_factor;
      end else begin
        s1_add <= ADD_W'({pixel_intensity[30:0], 16'b0});
      end
    end
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      acc[r] = 42'(prod[r][0]) + 42'(prod[r][1]) + 42'(prod[r][2]);
    end
    cx = 16'(acc[0] >>> 28) + 16'(GRID_X / HALF_DIV);
    cy = 16'(acc[1] >>> 28) + 16'(GRID_Y / HALF_DIV);
    cz = 16'(acc[2] >>> 28) + 16'(GRID_Z / HALF_DIV);
    in_grid = !cx[15] && (cx < $signed(16'(GRID_X))) &&
              !cy[15] && (cy < $signed(16'(GRID_Y))) &&
              !cz[15] && (cz < $signed(16'(GRID_Z)));
    flat = 32'(cx[8:0]) * 32'(YZ) + 32'(cy[8:0]) * 32'(GRID_Z) + 32'(cz[8:0]);
    push_data.op = s1_op;
    push_data.add = s1_add;
    if (s1_op == OP_READ) begin
      push_data.hit = 1'b0;
      push_data.addr = s1_addr;
    end else if (in_grid && !s1_neg) begin
      push_data.hit = 1'b1;
      push_data.addr = flat[ADDR_W-1:0];
    end else begin
      push_data.hit = 1'b0;
      push_data.addr = '0;
    end
  end

  assign push = s1_valid;

endmodule

### hw/rtl/rvb_divider.sv
// ----------------------------------------------------------------------------
// Average divider
// Restoring divider of a 64-bit sum by a 32-bit count, one bit a cycle.
// ----------------------------------------------------------------------------
module rvb_divider (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [63:0] quotient
);
  logic        busy;
  logic [5:0]  cnt;
  logic [31:0] rem;
  logic [31:0] dsr;
  logic [32:0] trial;
  logic        fits;

  assign trial = {rem, quotient[63]};
  assign fits = trial >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= '0;
      end else if (busy) begin
        cnt <= cnt + 6'd1;
        if (cnt == 6'd63) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      rem <= '0;
      dsr <= divisor;
    end else if (busy) begin
      quotient <= {quotient[62:0], fits};
      rem <= fits ? 32'(trial - {1'b0, dsr}) : trial[31:0];
    end
  end

endmodule

### hw/rtl/rvb_back.sv
// ----------------------------------------------------------------------------
// Voxel binning back
// Clears the voxel stores after reset, then carries out queued words:
// read-modify-write of a voxel or an averaged readout.
// ----------------------------------------------------------------------------
module rvb_back (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       head_valid,
  input  rvb_pkg::work_t             head_data,
  output logic                       pop,
  output logic                       clearing,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       landed,
  output logic [rvb_pkg::ADDR_W-1:0] landed_address,
  output logic [31:0]                average_value,
  output logic                       voxel_filled
);
  import rvb_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_DIV = 2'd2;
  localparam logic [1:0] S_FIN = 2'd3;

  logic [SUM_W-1:0]  sum_mem [STORE_DEPTH];
  logic [HITS_W-1:0] hits_mem [STORE_DEPTH];
  logic [1:0]        state;
  logic [ADDR_W-1:0] clr_idx;
  work_t             cur;
  logic [ADDR_W-1:0] rd_addr;
  logic [SUM_W-1:0]  rd_sum;
  logic [HITS_W-1:0] rd_hits;
  logic              we;
  logic [ADDR_W-1:0] waddr;
  logic [SUM_W-1:0]  wsum;
  logic [HITS_W-1:0] whits;
  logic [SUM_W:0]    sum_ext;
  logic              out_free;
  logic              div_start;
  logic              div_done;
  logic [63:0]       quo;
  logic              load;
  logic              load_landed;
  logic [31:0]       load_avg;
  logic              load_filled;

  assign out_free = !out_valid || out_ready;
  assign pop = (state == S_IDLE) && !clearing && head_valid;
  assign rd_addr = (state == S_IDLE) ? head_data.addr : cur.addr;
  assign sum_ext = {1'b0, rd_sum} + (SUM_W + 1)'(cur.add);

  always_comb begin
    we = 1'b0;
    waddr = clr_idx;
    wsum = '0;
    whits = '0;
    load = 1'b0;
    load_landed = 1'b0;
    load_avg = '0;
    load_filled = 1'b0;
    div_start = 1'b0;
    if (clearing) begin
      we = 1'b1;
    end
    case (state)
      S_EXEC: begin
        if (cur.op == OP_ACCUM) begin
          if (out_free) begin
            load = 1'b1;
            load_landed = cur.hit;
            if (cur.hit) begin
              we = 1'b1;
              waddr = cur.addr;
              wsum = sum_ext[SUM_W] ? '1 : sum_ext[SUM_W-1:0];
              whits = (rd_hits == '1) ? rd_hits : rd_hits + 32'd1;
            end
          end
        end else if (rd_sum != '0 && rd_hits != '0) begin
          div_start = 1'b1;
        end else if (out_free) begin
          load = 1'b1;
        end
      end
      S_FIN: begin
        if (out_free) begin
          load = 1'b1;
          load_filled = 1'b1;
          load_avg = (quo < {24'b0, CLIP_LIMIT, 16'b0}) ? quo[39:8] : '0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      clearing <= 1'b1;
      clr_idx <= '0;
      out_valid <= 1'b0;
    end else begin
      if (clearing) begin
        clr_idx <= clr_idx + 1'b1;
        if (clr_idx == '1) begin
          clearing <= 1'b0;
        end
      end
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (pop) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (div_start) begin
            state <= S_DIV;
          end else if (load) begin
            state <= S_IDLE;
          end
        end
        S_DIV: begin
          if (div_done) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (load) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head_data;
    end
    if (load) begin
      landed <= load_landed;
      landed_address <= cur.addr;
      average_value <= load_avg;
      voxel_filled <= load_filled;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      sum_mem[waddr] <= wsum;
      hits_mem[waddr] <= whits;
    end
    rd_sum <= sum_mem[rd_addr];
    rd_hits <= hits_mem[rd_addr];
  end

  rvb_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (rd_sum),
    .divisor  (rd_hits),
    .done     (div_done),
    .quotient (quo)
  );

endmodule
